// ----- rtl/core/wtd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the window thermostat with duty bands.
// Holds widths, event and register codes, shared types and the conversion functions.
// No dependencies.
package wtd_pkg;

    localparam int ADC_BITS   = 10;
    localparam int TEMP_BITS  = 16;
    localparam int BYTE_BITS  = 8;
    localparam int FUNC_BITS  = 2;
    localparam int NUM_REGS   = 7;
    localparam int CFG_IDX_W  = 3;

    localparam int S_FIELD_W  = TEMP_BITS + ADC_BITS;
    localparam int S_TDATA_W  = ((S_FIELD_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
    localparam int M_FIELD_W  = BYTE_BITS + 4 + BYTE_BITS;
    localparam int M_TDATA_W  = ((M_FIELD_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;

    localparam logic [7:0] WHOLE_MASK = 8'h7F;

    localparam int ADC_CMP_W   = 16;
    localparam int ADC_T_FULL  = 700;
    localparam int ADC_T_HIGH  = 350;
    localparam int ADC_T_MID   = 200;
    localparam int ADC_T_LOW   = 100;
    localparam logic [7:0] DUTY_FULL = 8'd255;
    localparam logic [7:0] DUTY_HIGH = 8'd170;
    localparam logic [7:0] DUTY_MID  = 8'd70;
    localparam logic [7:0] DUTY_LOW  = 8'd20;
    localparam logic [7:0] DUTY_OFF  = 8'd0;

    localparam logic [7:0] RST_HEATER_LOW  = 8'd30;
    localparam logic [7:0] RST_HEATER_HIGH = 8'd32;
    localparam logic [7:0] RST_FIRST_LOW   = 8'd26;
    localparam logic [7:0] RST_FIRST_HIGH  = 8'd28;
    localparam logic [7:0] RST_SECOND_LOW  = 8'd29;
    localparam logic [7:0] RST_SECOND_HIGH = 8'd29;
    localparam logic [7:0] RST_ALARM_LEVEL = 8'd100;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_TEMP    = 2'd0,
        FUNC_ADC     = 2'd1,
        FUNC_MISSING = 2'd2,
        FUNC_IDLE    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEATER_LOW  = 3'd0,
        REG_HEATER_HIGH = 3'd1,
        REG_FIRST_LOW   = 3'd2,
        REG_FIRST_HIGH  = 3'd3,
        REG_SECOND_LOW  = 3'd4,
        REG_SECOND_HIGH = 3'd5,
        REG_ALARM_LEVEL = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] heater_low;
        logic [7:0] heater_high;
        logic [7:0] first_low;
        logic [7:0] first_high;
        logic [7:0] second_low;
        logic [7:0] second_high;
        logic [7:0] alarm_level;
    } cfg_regs_t;

    typedef struct packed {
        logic [7:0]        heater_duty;
        logic              first_on;
        logic              second_on;
        logic              buzz_on;
        logic              heat_allowed;
        logic signed [7:0] temp_whole;
    } wtd_state_t;

    // Sign/magnitude conversion, fraction dropped, whole part limited to 7 bits.
    function automatic logic signed [7:0] temp_to_whole(input logic [TEMP_BITS-1:0] word);
        logic [TEMP_BITS-1:0] mag;
        logic [7:0]           whole;
        mag   = word[TEMP_BITS-1] ? (~word + 1'b1) : word;
        whole = 8'(mag >> 4) & WHOLE_MASK;
        return word[TEMP_BITS-1] ? signed'(8'(-whole)) : signed'(whole);
    endfunction

    function automatic logic in_window(input logic [7:0] v, input logic [7:0] lo,
                                       input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [7:0] duty_band(input logic [ADC_BITS-1:0] sample);
        logic [ADC_CMP_W-1:0] s;
        s = ADC_CMP_W'(sample);
        if (s >= ADC_CMP_W'(ADC_T_FULL)) begin
            return DUTY_FULL;
        end else if (s >= ADC_CMP_W'(ADC_T_HIGH)) begin
            return DUTY_HIGH;
        end else if (s >= ADC_CMP_W'(ADC_T_MID)) begin
            return DUTY_MID;
        end else if (s >= ADC_CMP_W'(ADC_T_LOW)) begin
            return DUTY_LOW;
        end else begin
            return DUTY_OFF;
        end
    endfunction

endpackage

// ----- rtl/core/window_thermostat_with_duty_bands_unit.sv -----
`timescale 1ns / 1ps
// Window thermostat with duty bands, top level.
// Path: input register, update logic, result register; a stalled result holds both registers.
// Throughput: one item per cycle unless the result stalls; the update logic is one pass.
// Reset (aresetn, synchronous, active low): pipeline empty, state cleared, registers at defaults.
// Depends on wtd_pkg, wtd_cfg_regs, wtd_core.
module window_thermostat_with_duty_bands_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wtd_pkg::S_TDATA_W-1:0]   s_tdata,   // raw_temp[15:0], adc_sample[25:16]
    input  logic [wtd_pkg::FUNC_BITS-1:0]   s_tuser,   // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // heater_duty[7:0], first_on[8], second_on[9], buzz_on[10], heat_allowed[11],
    // temp_whole[19:12]
    output logic [wtd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wtd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import wtd_pkg::*;

    logic                   in_valid_reg;
    logic [FUNC_BITS-1:0]   in_func_reg;
    logic [TEMP_BITS-1:0]   in_temp_reg;
    logic [ADC_BITS-1:0]    in_adc_reg;
    logic                   out_valid_reg;
    wtd_state_t             out_data_reg;
    wtd_state_t             state_next;
    cfg_regs_t              cfg;
    logic                   advance;
    logic                   s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    wtd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wtd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .func       (in_func_reg),
        .raw_temp   (in_temp_reg),
        .adc_sample (in_adc_reg),
        .cfg        (cfg),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg <= s_tuser;
            in_temp_reg <= s_tdata[TEMP_BITS-1:0];
            in_adc_reg  <= s_tdata[TEMP_BITS +: ADC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_data_reg.temp_whole,
                                  out_data_reg.heat_allowed,
                                  out_data_reg.buzz_on,
                                  out_data_reg.second_on,
                                  out_data_reg.first_on,
                                  out_data_reg.heater_duty});

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("input item dropped while result stalled");

endmodule

// ----- rtl/core/wtd_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file: window bounds and alarm level.
// Depends on wtd_pkg.
module wtd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wtd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    output wtd_pkg::cfg_regs_t              cfg
);
    import wtd_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_HEATER_LOW:  cfg_next.heater_low  = cfg_data;
                REG_HEATER_HIGH: cfg_next.heater_high = cfg_data;
                REG_FIRST_LOW:   cfg_next.first_low   = cfg_data;
                REG_FIRST_HIGH:  cfg_next.first_high  = cfg_data;
                REG_SECOND_LOW:  cfg_next.second_low  = cfg_data;
                REG_SECOND_HIGH: cfg_next.second_high = cfg_data;
                REG_ALARM_LEVEL: cfg_next.alarm_level = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heater_low  <= RST_HEATER_LOW;
            cfg_reg.heater_high <= RST_HEATER_HIGH;
            cfg_reg.first_low   <= RST_FIRST_LOW;
            cfg_reg.first_high  <= RST_FIRST_HIGH;
            cfg_reg.second_low  <= RST_SECOND_LOW;
            cfg_reg.second_high <= RST_SECOND_HIGH;
            cfg_reg.alarm_level <= RST_ALARM_LEVEL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/wtd_core.sv -----
`timescale 1ns / 1ps
// Thermostat state and per-item update: temperature, converter and sensor-missing events.
// Depends on wtd_pkg.
module wtd_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    input  logic [wtd_pkg::FUNC_BITS-1:0]  func,
    input  logic [wtd_pkg::TEMP_BITS-1:0]  raw_temp,
    input  logic [wtd_pkg::ADC_BITS-1:0]   adc_sample,
    input  wtd_pkg::cfg_regs_t             cfg,
    output wtd_pkg::wtd_state_t            state_next
);
    import wtd_pkg::*;

    wtd_state_t        state_reg;
    logic signed [7:0] value;
    logic [7:0]        value_u;
    logic              act;

    assign value   = temp_to_whole(raw_temp);
    assign value_u = 8'(value);
    // act needs a clear sign bit and the same whole value as the last temperature reading
    assign act     = !raw_temp[TEMP_BITS-1] && (value == state_reg.temp_whole);

    always_comb begin
        state_next = state_reg;
        case (func_t'(func))
            FUNC_TEMP: begin
                if (act) begin
                    if (in_window(value_u, cfg.heater_low, cfg.heater_high)) begin
                        state_next.heat_allowed = 1'b1;
                    end else begin
                        state_next.heat_allowed = 1'b0;
                        state_next.heater_duty  = DUTY_OFF;
                    end
                    state_next.first_on  = in_window(value_u, cfg.first_low, cfg.first_high);
                    state_next.second_on = in_window(value_u, cfg.second_low, cfg.second_high);
                    state_next.buzz_on   = value_u >= cfg.alarm_level;
                end
                state_next.temp_whole = value;
            end
            FUNC_ADC: begin
                if (state_reg.heat_allowed) begin
                    state_next.heater_duty = duty_band(adc_sample);
                end
            end
            FUNC_MISSING: begin
                state_next.heater_duty = DUTY_OFF;
                state_next.first_on    = 1'b0;
                state_next.second_on   = 1'b0;
            end
            default: state_next = state_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (item_valid) begin
            state_reg <= state_next;
        end
    end

    // duty can only be nonzero while heating is allowed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.heat_allowed |-> (state_reg.heater_duty == DUTY_OFF))
        else $error("heater duty nonzero while heating not allowed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && (func_t'(func) != FUNC_TEMP)) |=> $stable(state_reg.temp_whole))
        else $error("last reading changed by a non-temperature item");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for window_thermostat_with_duty_bands_unit: directed rows, then random event
// streams under several register settings, checked against a local model or typed rows.
// Depends on wtd_pkg and the unit's RTL.
module testbench;
    import wtd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 60;

    typedef struct {
        func_t      func;
        logic [15:0] raw;
        logic [9:0] adc;
        bit         typed;
        wtd_state_t status;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_BITS-1:0] s_tuser = FUNC_IDLE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    // local model of the thermostat
    logic [7:0]        cfg_shadow [0:NUM_REGS-1];
    logic signed [7:0] last_temp;
    logic              heat_ok;
    logic [7:0]        duty_now;
    logic              first_now;
    logic              second_now;
    logic              buzz_now;

    wtd_state_t status_q[$];
    stim_row_t  stim_rows[$];
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int settings_used = 1;
    int hold_left = 0;
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;

    window_thermostat_with_duty_bands_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit between(input int v, input logic [7:0] lo, input logic [7:0] hi);
        return v >= int'(lo) && v <= int'(hi);
    endfunction

    function automatic wtd_state_t advance_thermostat(input func_t f, input logic [15:0] raw,
                                                      input logic [9:0] adc);
        logic        neg;
        logic [15:0] mag;
        int          whole;
        int          value;
        wtd_state_t  r;
        case (f)
            FUNC_TEMP: begin
                neg = raw[15];
                mag = neg ? 16'(~raw + 16'd1) : raw;
                whole = int'(mag[10:4]);
                value = neg ? -whole : whole;
                if (!neg && value == int'(last_temp)) begin
                    if (between(value, cfg_shadow[REG_HEATER_LOW],
                                cfg_shadow[REG_HEATER_HIGH])) begin
                        heat_ok = 1'b1;
                    end else begin
                        heat_ok = 1'b0;
                        duty_now = 8'd0;
                    end
                    first_now = between(value, cfg_shadow[REG_FIRST_LOW],
                                        cfg_shadow[REG_FIRST_HIGH]);
                    second_now = between(value, cfg_shadow[REG_SECOND_LOW],
                                         cfg_shadow[REG_SECOND_HIGH]);
                    buzz_now = value >= int'(cfg_shadow[REG_ALARM_LEVEL]);
                end
                last_temp = 8'(value);
            end
            FUNC_ADC: begin
                if (heat_ok) begin
                    if (adc >= 10'd700) duty_now = 8'd255;
                    else if (adc >= 10'd350) duty_now = 8'd170;
                    else if (adc >= 10'd200) duty_now = 8'd70;
                    else if (adc >= 10'd100) duty_now = 8'd20;
                    else duty_now = 8'd0;
                end
            end
            FUNC_MISSING: begin
                duty_now = 8'd0;
                first_now = 1'b0;
                second_now = 1'b0;
            end
            default: ;
        endcase
        r.heater_duty = duty_now;
        r.first_on = first_now;
        r.second_on = second_now;
        r.buzz_on = buzz_now;
        r.heat_allowed = heat_ok;
        r.temp_whole = last_temp;
        return r;
    endfunction

    function automatic wtd_state_t mk_status(input logic [7:0] duty, input logic f1,
                                             input logic f2, input logic bz, input logic al,
                                             input logic signed [7:0] t);
        wtd_state_t r;
        r.heater_duty = duty;
        r.first_on = f1;
        r.second_on = f2;
        r.buzz_on = bz;
        r.heat_allowed = al;
        r.temp_whole = t;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [6:0] pick_degree();
        int k;
        int j;
        int d;
        if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
        k = $urandom_range(0, NUM_REGS - 1);
        j = $urandom_range(0, 4);
        d = int'(cfg_shadow[k]) + j - 2;
        if (d < 0) d = 0;
        if (d > 127) d = 127;
        return 7'(d);
    endfunction

    function automatic logic [9:0] pick_sample();
        int edges [10] = '{0, 99, 100, 199, 200, 349, 350, 699, 700, 1023};
        if ($urandom_range(0, 1) == 0) return 10'($urandom_range(0, 1023));
        return 10'(edges[$urandom_range(0, 9)]);
    endfunction

    task automatic add_row(input func_t f, input logic [15:0] raw, input logic [9:0] adc,
                           input bit typed, input wtd_state_t st);
        stim_row_t row;
        row.func = f;
        row.raw = raw;
        row.adc = adc;
        row.typed = typed;
        row.status = st;
        stim_rows.push_back(row);
    endtask

    task automatic send_item(input func_t f, input logic [15:0] raw, input logic [9:0] adc,
                             input bit typed, input wtd_state_t st);
        int gap;
        wtd_state_t got;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= S_TDATA_W'({adc, raw});
        do @(posedge aclk); while (!s_tready);
        got = advance_thermostat(f, raw, adc);
        status_q.push_back(typed ? st : got);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (int'(idx) < NUM_REGS) cfg_shadow[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic temp_pair(input bit neg);
        logic [6:0]  deg;
        logic [15:0] w;
        int n;
        deg = pick_degree();
        for (n = 0; n < 2; n++) begin
            if (neg) w = 16'd0 - {5'd0, deg, 4'($urandom_range(0, 15))};
            else w = {1'b0, 4'($urandom_range(0, 15)), deg, 4'($urandom_range(0, 15))};
            send_item(FUNC_TEMP, w, 10'($urandom_range(0, 1023)), 1'b0, '0);
        end
    endtask

    task automatic check_status(input logic [M_TDATA_W-1:0] d);
        wtd_state_t want;
        wtd_state_t seen;
        seen = mk_status(d[7:0], d[8], d[9], d[10], d[11], d[19:12]);
        if (status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", d);
            return;
        end
        want = status_q.pop_front();
        results_checked++;
        if (seen.heater_duty !== want.heater_duty || seen.first_on !== want.first_on ||
            seen.second_on !== want.second_on || seen.buzz_on !== want.buzz_on ||
            seen.heat_allowed !== want.heat_allowed || seen.temp_whole !== want.temp_whole ||
            d[M_TDATA_W-1:20] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: expected duty %0d out1 %b out2 %b buzz %b allow %b temp %0d",
                         results_checked, want.heater_duty, want.first_on, want.second_on,
                         want.buzz_on, want.heat_allowed, want.temp_whole);
                $display("result %0d:   actual duty %0d out1 %b out2 %b buzz %b allow %b temp %0d",
                         results_checked, seen.heater_duty, seen.first_on, seen.second_on,
                         seen.buzz_on, seen.heat_allowed, seen.temp_whole);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_status(m_tdata);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
            hold_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int phase;
        int k;
        int lo;
        int hi;
        int sent;
        int pick;
        stim_row_t row;

        cfg_shadow[REG_HEATER_LOW] = RST_HEATER_LOW;
        cfg_shadow[REG_HEATER_HIGH] = RST_HEATER_HIGH;
        cfg_shadow[REG_FIRST_LOW] = RST_FIRST_LOW;
        cfg_shadow[REG_FIRST_HIGH] = RST_FIRST_HIGH;
        cfg_shadow[REG_SECOND_LOW] = RST_SECOND_LOW;
        cfg_shadow[REG_SECOND_HIGH] = RST_SECOND_HIGH;
        cfg_shadow[REG_ALARM_LEVEL] = RST_ALARM_LEVEL;
        last_temp = '0;
        heat_ok = 1'b0;
        duty_now = '0;
        first_now = 1'b0;
        second_now = 1'b0;
        buzz_now = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset register values
        add_row(FUNC_IDLE, 16'h1234, 10'h155, 1'b1,
                mk_status(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0));
        add_row(FUNC_TEMP, 16'h0000, 10'h3FF, 1'b1,
                mk_status(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0));
        add_row(FUNC_TEMP, 16'hFFFF, 10'h000, 1'b1,
                mk_status(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0));
        add_row(FUNC_TEMP, 16'h8000, 10'h2AA, 1'b1,
                mk_status(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0));
        add_row(FUNC_TEMP, 16'h7FFF, 10'h000, 1'b1,
                mk_status(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd127));
        add_row(FUNC_TEMP, 16'h07F0, 10'h000, 1'b1,
                mk_status(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 8'sd127));
        add_row(FUNC_ADC,  16'hFFFF, 10'd1023, 1'b1,
                mk_status(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 8'sd127));
        add_row(FUNC_TEMP, 16'h01E0, 10'd0, 1'b0, '0);
        add_row(FUNC_TEMP, 16'h01EF, 10'd0, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd1023, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd700, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd699, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd350, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd349, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd200, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd199, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd100, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd99, 1'b0, '0);
        add_row(FUNC_ADC,  16'h0000, 10'd700, 1'b0, '0);
        add_row(FUNC_MISSING, 16'hFFFF, 10'd1023, 1'b0, '0);
        add_row(FUNC_TEMP, 16'h01C0, 10'd0, 1'b0, '0);
        add_row(FUNC_TEMP, 16'h01C0, 10'd0, 1'b0, '0);
        add_row(FUNC_TEMP, 16'h01D0, 10'd0, 1'b0, '0);
        add_row(FUNC_TEMP, 16'h01D5, 10'd0, 1'b0, '0);
        add_row(FUNC_TEMP, 16'hFE20, 10'd0, 1'b0, '0);
        add_row(FUNC_TEMP, 16'hFE20, 10'd0, 1'b0, '0);

        src_steady = 1'b1;
        sink_steady = 1'b1;
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (i == 12) src_steady = 1'b0;
            send_item(row.func, row.raw, row.adc, row.typed, row.status);
        end
        s_tvalid <= 1'b0;
        sink_steady = 1'b0;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            while (status_q.size() != 0) @(posedge aclk);
            for (k = 0; k < 3; k++) begin
                case (phase)
                    0: begin lo = 0; hi = 0; end
                    1: begin lo = 200; hi = 200; end
                    2: begin lo = 0; hi = 200; end
                    3: begin hi = $urandom_range(0, 100); lo = hi + $urandom_range(1, 20); end
                    default: begin lo = $urandom_range(0, 120); hi = lo + $urandom_range(0, 10); end
                endcase
                write_reg(CFG_IDX_W'(2 * k), 8'(lo));
                write_reg(CFG_IDX_W'(2 * k + 1), 8'(hi));
            end
            case (phase)
                0: write_reg(REG_ALARM_LEVEL, 8'd0);
                1, 2: write_reg(REG_ALARM_LEVEL, 8'd200);
                default: write_reg(REG_ALARM_LEVEL, 8'($urandom_range(0, 130)));
            endcase
            write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
            settings_used++;
            src_steady = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2: begin temp_pair(1'b0); sent += 2; end
                    3: begin temp_pair(1'b1); sent += 2; end
                    4, 5, 6: begin
                        send_item(FUNC_ADC, 16'($urandom_range(0, 65535)), pick_sample(),
                                  1'b0, '0);
                        sent++;
                    end
                    7: begin
                        send_item(FUNC_MISSING, 16'($urandom_range(0, 65535)),
                                  10'($urandom_range(0, 1023)), 1'b0, '0);
                        sent++;
                    end
                    8: begin
                        send_item(FUNC_TEMP, 16'($urandom_range(0, 65535)),
                                  10'($urandom_range(0, 1023)), 1'b0, '0);
                        sent++;
                    end
                    default: begin
                        send_item(FUNC_IDLE, 16'($urandom_range(0, 65535)),
                                  10'($urandom_range(0, 1023)), 1'b0, '0);
                        sent++;
                    end
                endcase
            end
            s_tvalid <= 1'b0;
        end

        sink_steady = 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        mismatches += status_q.size();

        $display("Sent %0d items and checked %0d results across %0d register settings",
                 items_sent, results_checked, settings_used);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad results", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
